### rtl/olist_pkg.sv
// Package for the ordered handle list: parameter defaults, field widths,
// action and status codes, and the token control struct passed between cells.
// No dependencies.
`default_nettype none

package olist_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned HANDLE_BITS = 32;

  localparam int unsigned ACTION_BITS = 3;
  localparam int unsigned POS_BITS    = 6;
  localparam int unsigned FIDX_BITS   = 6;
  localparam int unsigned COUNT_BITS  = 7;
  localparam int unsigned STATUS_BITS = 2;

  localparam logic [ACTION_BITS-1:0] ACT_APPEND       = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_READ         = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_FIND         = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_REMOVE_VALUE = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_REMOVE_AT    = 3'd4;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR        = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

  // Control part of the token walking down the cell row.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

endpackage

`default_nettype wire

### rtl/olist_if.sv
// Valid/ready channel interfaces for the ordered handle list: command words
// in, result words out. Depends on olist_pkg for widths.
`default_nettype none

interface olist_in_if #(
  parameter int unsigned HandleBits = olist_pkg::HANDLE_BITS
) ();
  logic                                 valid;
  logic                                 ready;
  logic [olist_pkg::ACTION_BITS-1:0]    action;
  logic [HandleBits-1:0]                handle;
  logic [olist_pkg::POS_BITS-1:0]       position;

  modport source (output valid, action, handle, position, input ready);
  modport sink   (input valid, action, handle, position, output ready);
endinterface

interface olist_out_if #(
  parameter int unsigned HandleBits = olist_pkg::HANDLE_BITS
) ();
  logic                                 valid;
  logic                                 ready;
  logic [HandleBits-1:0]                read_handle;
  logic [olist_pkg::FIDX_BITS-1:0]      found_index;
  logic [olist_pkg::COUNT_BITS-1:0]     live_count;
  logic [olist_pkg::STATUS_BITS-1:0]    status;

  modport source (output valid, read_handle, found_index, live_count, status, input ready);
  modport sink   (input valid, read_handle, found_index, live_count, status, output ready);
endinterface

`default_nettype wire

### rtl/olist_cell.sv
// One cell of the ordered handle list: holds one entry and acts on the token
// as it passes, then hands the token to the next cell. Depends on olist_pkg.
`default_nettype none

module olist_cell #(
  parameter int unsigned Capacity   = olist_pkg::CAPACITY,
  parameter int unsigned HandleBits = olist_pkg::HANDLE_BITS,
  parameter int unsigned Index      = 0
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 adv_i,
  input  wire logic [$clog2(Capacity+1)-1:0]        count_i,
  input  wire logic [olist_pkg::ACTION_BITS-1:0]    action_i,
  input  wire logic [HandleBits-1:0]                key_i,
  input  wire logic [olist_pkg::POS_BITS-1:0]       pos_i,
  input  wire logic [HandleBits-1:0]                nbr_entry_i,
  output      logic [HandleBits-1:0]                entry_o,
  input  wire olist_pkg::tok_ctl_t                  ctl_i,
  input  wire logic [$clog2(Capacity)-1:0]          fidx_i,
  input  wire logic [HandleBits-1:0]                rd_i,
  output      olist_pkg::tok_ctl_t                  ctl_o,
  output      logic [$clog2(Capacity)-1:0]          fidx_o,
  output      logic [HandleBits-1:0]                rd_o
);

  localparam int unsigned CW   = $clog2(Capacity + 1);
  localparam int unsigned IW   = $clog2(Capacity);
  localparam int unsigned CmpW = (CW > olist_pkg::POS_BITS) ? CW : olist_pkg::POS_BITS;

  localparam logic [CW-1:0]   IdxC = CW'(Index);
  localparam logic [IW-1:0]   IdxF = IW'(Index);
  localparam logic [CmpW-1:0] IdxP = CmpW'(Index);

  logic [HandleBits-1:0] entry_q, entry_d;
  olist_pkg::tok_ctl_t   ctl_q, ctl_d;
  logic [IW-1:0]         fidx_q, fidx_d;
  logic [HandleBits-1:0] rd_q, rd_d;

  logic live, at_pos, eq, hit;

  always_comb begin
    live    = IdxC < count_i;
    at_pos  = CmpW'(pos_i) == IdxP;
    eq      = entry_q == key_i;
    hit     = 1'b0;
    entry_d = entry_q;
    ctl_d   = ctl_i;
    fidx_d  = fidx_i;
    rd_d    = rd_i;
    if (ctl_i.valid) begin
      case (action_i)
        olist_pkg::ACT_APPEND: begin
          if (IdxC == count_i) entry_d = key_i;
        end
        olist_pkg::ACT_READ: begin
          hit = live && at_pos;
          if (hit) begin
            rd_d        = entry_q;
            ctl_d.found = 1'b1;
          end
        end
        olist_pkg::ACT_FIND: begin
          hit = live && !ctl_i.found && eq;
          if (hit) begin
            fidx_d      = IdxF;
            ctl_d.found = 1'b1;
          end
        end
        olist_pkg::ACT_REMOVE_VALUE: begin
          hit         = live && !ctl_i.found && eq;
          ctl_d.found = ctl_i.found | hit;
          // close the gap: pull the neighbor down before the token reaches it
          if (live && ctl_d.found) entry_d = nbr_entry_i;
        end
        olist_pkg::ACT_REMOVE_AT: begin
          hit         = live && at_pos;
          ctl_d.found = ctl_i.found | hit;
          if (live && ctl_d.found) entry_d = nbr_entry_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      entry_q <= entry_d;
      fidx_q  <= fidx_d;
      rd_q    <= rd_d;
    end
  end

  assign entry_o = entry_q;
  assign ctl_o   = ctl_q;
  assign fidx_o  = fidx_q;
  assign rd_o    = rd_q;

endmodule

`default_nettype wire

### rtl/ordered_handle_list.sv
// Top level of the ordered handle list: command register, row of cells,
// live count and output register. Depends on olist_pkg, olist_if, olist_cell.
//
//   channel  dir  modport              word
//   in_i     in   olist_in_if.sink     action, handle, position
//   out_o    out  olist_out_if.source  read_handle, found_index, live_count, status
//
// Each accepted word enters the start register, then a token walks the row of cells
// one cell per cycle while the row is not held; only one word is in the row.
// The next word is accepted once the token has left the row, even while the previous
// result waits in the output register.
// Reset clears the count and the control state; entries are left as they are.
// If a result waits and the next token reaches the end of the row, the row holds.
`default_nettype none

module ordered_handle_list #(
  parameter int unsigned Capacity   = olist_pkg::CAPACITY,
  parameter int unsigned HandleBits = olist_pkg::HANDLE_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  olist_in_if.sink   in_i,
  olist_out_if.source out_o
);

  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned IW = $clog2(Capacity);
  localparam int unsigned FW = (IW > olist_pkg::FIDX_BITS) ? IW : olist_pkg::FIDX_BITS;
  localparam int unsigned LW = (CW > olist_pkg::COUNT_BITS) ? CW : olist_pkg::COUNT_BITS;
  localparam logic [CW-1:0] CapC = CW'(Capacity);

  logic                                 busy_q;
  logic [olist_pkg::ACTION_BITS-1:0]    action_q;
  logic [HandleBits-1:0]                key_q;
  logic [olist_pkg::POS_BITS-1:0]       pos_q;
  olist_pkg::tok_ctl_t                  start_q;
  logic [CW-1:0]                        count_q, count_d;

  logic                                 out_valid_q;
  logic [HandleBits-1:0]                rd_q;
  logic [olist_pkg::FIDX_BITS-1:0]      fidx_q;
  logic [olist_pkg::COUNT_BITS-1:0]     cnt_out_q;
  logic [olist_pkg::STATUS_BITS-1:0]    status_q, status_d;

  olist_pkg::tok_ctl_t   ctl_w   [0:Capacity];
  logic [IW-1:0]         fidx_w  [0:Capacity];
  logic [HandleBits-1:0] rd_w    [0:Capacity];
  logic [HandleBits-1:0] entry_w [0:Capacity-1];
  logic [Capacity:0]     tok_vec;

  logic accept, adv, done;
  logic [FW-1:0] fidx_ext;
  logic [LW-1:0] cnt_ext;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = !busy_q;
  // hold the row while a finished token cannot enter the output register
  assign adv  = !(ctl_w[Capacity].valid && out_valid_q && !out_o.ready);
  assign done = ctl_w[Capacity].valid && adv;

  assign ctl_w[0]  = start_q;
  assign fidx_w[0] = '0;
  assign rd_w[0]   = '0;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [HandleBits-1:0] nbr;
    if (i < Capacity - 1) begin : g_mid
      assign nbr = entry_w[i+1];
    end else begin : g_last
      assign nbr = entry_w[i];
    end
    olist_cell #(
      .Capacity   (Capacity),
      .HandleBits (HandleBits),
      .Index      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .count_i     (count_q),
      .action_i    (action_q),
      .key_i       (key_q),
      .pos_i       (pos_q),
      .nbr_entry_i (nbr),
      .entry_o     (entry_w[i]),
      .ctl_i       (ctl_w[i]),
      .fidx_i      (fidx_w[i]),
      .rd_i        (rd_w[i]),
      .ctl_o       (ctl_w[i+1]),
      .fidx_o      (fidx_w[i+1]),
      .rd_o        (rd_w[i+1])
    );
  end

  for (genvar i = 0; i <= Capacity; i++) begin : g_vec
    assign tok_vec[i] = ctl_w[i].valid;
  end

  // Finish the word as the token leaves the last cell.
  always_comb begin
    count_d  = count_q;
    status_d = olist_pkg::ST_OK;
    unique case (action_q)
      olist_pkg::ACT_APPEND: begin
        if (count_q >= CapC) status_d = olist_pkg::ST_FULL;
        else                 count_d  = count_q + CW'(1);
      end
      olist_pkg::ACT_READ, olist_pkg::ACT_FIND: begin
        if (!ctl_w[Capacity].found) status_d = olist_pkg::ST_MISS;
      end
      olist_pkg::ACT_REMOVE_VALUE, olist_pkg::ACT_REMOVE_AT: begin
        if (ctl_w[Capacity].found) count_d  = count_q - CW'(1);
        else                       status_d = olist_pkg::ST_MISS;
      end
      olist_pkg::ACT_CLEAR: count_d = '0;
      default: begin
      end
    endcase
  end

  assign fidx_ext = FW'(fidx_w[Capacity]);
  assign cnt_ext  = LW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q  <= 1'b1;
      end else if (done) begin
        busy_q  <= 1'b0;
      end
      if (accept) begin
        start_q <= '{valid: 1'b1, found: 1'b0};
      end else if (adv) begin
        start_q <= '0;
      end
      if (done) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= in_i.action;
      key_q    <= in_i.handle;
      pos_q    <= in_i.position;
    end
    if (done) begin
      rd_q      <= rd_w[Capacity];
      fidx_q    <= fidx_ext[olist_pkg::FIDX_BITS-1:0];
      cnt_out_q <= cnt_ext[olist_pkg::COUNT_BITS-1:0];
      status_q  <= status_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_handle = rd_q;
  assign out_o.found_index = fidx_q;
  assign out_o.live_count  = cnt_out_q;
  assign out_o.status      = status_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("live count above capacity");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vec) <= 1)
    else $error("more than one token in the cell row");

  a_busy_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vec != '0) |-> busy_q)
    else $error("token in the row while idle");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done |=> $stable(count_q))
    else $error("count changed without a finished word");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> start_q.valid)
    else $error("accepted word did not enter the row");
`endif

endmodule

`default_nettype wire
